// File: src/cpd_pkg.sv
package cpd_pkg;

   localparam int BYTE_W      = 8;
   localparam int CHAN_W      = 7;
   localparam int KIND_W      = 3;
   localparam int SLOT_OUT_W  = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 8;

   localparam logic [BYTE_W-1:0] LEN_OVERHEAD = 8'd3;
   localparam logic [BYTE_W-1:0] CAPACITY_RESET = 8'd252;

   localparam logic [KIND_W-1:0] KIND_SYNC       = 3'd0;
   localparam logic [KIND_W-1:0] KIND_HEADER     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DATA       = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REGISTERED = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TABLE_FULL = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_CODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TYPE_REPLY  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TYPE_WRITE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TYPE_EOF    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TYPE_SETOPT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TYPE_RESET  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RX_CAPACITY = 3'd6;

   localparam logic MODE_RX_BYTE  = 1'b0;
   localparam logic MODE_REGISTER = 1'b1;

   typedef enum logic [4:0] {
      PH_IDLE = 5'b00001,
      PH_LEN  = 5'b00010,
      PH_CHAN = 5'b00100,
      PH_DATA = 5'b01000,
      PH_SKIP = 5'b10000
   } phase_type;

   typedef struct packed {
      logic              mode;
      logic [BYTE_W-1:0] rx_byte;
      logic [CHAN_W-1:0] channel;
      logic              keep_after_reply;
   } req_word_type;

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [CHAN_W-1:0]     chan_id;
      logic [SLOT_OUT_W-1:0] slot;
      logic [BYTE_W-1:0]     type_code;
      logic [BYTE_W-1:0]     length;
      logic [BYTE_W-1:0]     data_byte;
      logic                  done_res;
   } rsp_word_type;

   typedef struct packed {
      logic              reg_en;
      logic              reg_keep;
      logic [CHAN_W-1:0] reg_chan;
      logic              free_en;
   } tab_cmd_type;

   typedef struct packed {
      logic reg_found;
      logic match_hit;
   } tab_status_type;

endpackage

// File: src/cpd_stream_if.sv
interface cpd_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: src/cpd_slot_table.sv
module cpd_slot_table #(
   parameter int SLOT_COUNT = 4,
   parameter int SLOT_IDX_W = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cpd_pkg::tab_cmd_type          cmd,
   input  logic [SLOT_IDX_W-1:0]         free_slot,
   input  logic [cpd_pkg::BYTE_W-1:0]    match_byte,
   output logic [SLOT_IDX_W-1:0]         reg_slot,
   output logic [SLOT_IDX_W-1:0]         match_slot,
   output cpd_pkg::tab_status_type       status
);

   logic                       slot_valid_ff [SLOT_COUNT];
   logic                       slot_valid_in [SLOT_COUNT];
   logic [cpd_pkg::CHAN_W-1:0] slot_chan_ff  [SLOT_COUNT];
   logic                       slot_keep_ff  [SLOT_COUNT];

   // first free or same-channel slot; first valid slot holding the frame channel
   always_comb begin
      status.reg_found = 1'b0;
      status.match_hit = 1'b0;
      reg_slot         = '0;
      match_slot       = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!slot_valid_ff[i] || slot_chan_ff[i] == cmd.reg_chan) begin
            status.reg_found = 1'b1;
            reg_slot         = SLOT_IDX_W'(i);
         end
         if (slot_valid_ff[i] && !match_byte[cpd_pkg::BYTE_W-1] &&
             slot_chan_ff[i] == match_byte[cpd_pkg::CHAN_W-1:0]) begin
            status.match_hit = 1'b1;
            match_slot       = SLOT_IDX_W'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         slot_valid_in[i] = slot_valid_ff[i];
         if (cmd.reg_en && status.reg_found && reg_slot == SLOT_IDX_W'(i)) begin
            slot_valid_in[i] = 1'b1;
         end
         if (cmd.free_en && free_slot == SLOT_IDX_W'(i) && !slot_keep_ff[i]) begin
            slot_valid_in[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (reset) begin
            slot_valid_ff[i] <= 1'b0;
         end else begin
            slot_valid_ff[i] <= slot_valid_in[i];
         end
         if (cmd.reg_en && status.reg_found && reg_slot == SLOT_IDX_W'(i)) begin
            slot_chan_ff[i] <= cmd.reg_chan;
            slot_keep_ff[i] <= cmd.reg_keep;
         end
      end
   end

   a_reg_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.reg_en && status.reg_found |=> slot_valid_ff[$past(reg_slot)])
      else $error("registered slot not marked valid");

   a_reg_sets_chan: assert property (@(posedge clock) disable iff (reset)
      cmd.reg_en && status.reg_found |=>
         slot_chan_ff[$past(reg_slot)] == $past(cmd.reg_chan))
      else $error("registered slot holds wrong channel");

   a_free_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.free_en && !cmd.reg_en && !slot_keep_ff[free_slot] |=>
         !slot_valid_ff[$past(free_slot)])
      else $error("finished frame did not free its slot");

endmodule

// File: src/channel_packet_deframer_unit.sv
// Receive-side deframer for a length-prefixed channel protocol.
// req_port (sink) takes one word per handshake: either a received line byte
// (mode 0) or a channel registration (mode 1). rsp_port (source) returns at
// most one event word per request word: sync echo, frame header, payload
// byte, registered, or table full.
// csr_we/csr_index/csr_wdata write the sync code, the five accepted type
// codes and the receive capacity; write only while the block is idle.
// Throughput: one request word per cycle while rsp_port is ready. An event is
// registered and appears on rsp_port in the cycle after its request word is
// accepted. Slot matching compares all SLOT_COUNT entries combinationally.
// If the receiver stalls, the event is held in the output register and
// req_port stays ready only if that register drains in the same cycle.
// Reset (synchronous) returns the frame parser to idle, frees every slot,
// restores default register values and drops any pending event.
module channel_packet_deframer_unit #(
   parameter int SLOT_COUNT = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   cpd_stream_if.sink                        req_port,
   cpd_stream_if.source                      rsp_port,
   input  logic                              csr_we,
   input  logic [cpd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cpd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   logic [cpd_pkg::BYTE_W-1:0] sync_code_ff;
   logic [cpd_pkg::BYTE_W-1:0] type_reply_ff;
   logic [cpd_pkg::BYTE_W-1:0] type_write_ff;
   logic [cpd_pkg::BYTE_W-1:0] type_eof_ff;
   logic [cpd_pkg::BYTE_W-1:0] type_setopt_ff;
   logic [cpd_pkg::BYTE_W-1:0] type_reset_ff;
   logic [cpd_pkg::BYTE_W-1:0] rx_capacity_ff;

   cpd_pkg::phase_type         phase_ff, phase_in;
   logic [cpd_pkg::BYTE_W-1:0] frame_type_ff, frame_type_in;
   logic [cpd_pkg::BYTE_W-1:0] bytes_left_ff, bytes_left_in;
   logic [cpd_pkg::CHAN_W-1:0] frame_chan_ff, frame_chan_in;
   logic [SLOT_IDX_W-1:0]      frame_slot_ff, frame_slot_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   cpd_pkg::rsp_word_type      rsp_word_ff, rsp_word_in;
   logic                       emit;

   cpd_pkg::req_word_type      req_word;
   logic                       req_accept;
   logic [cpd_pkg::BYTE_W-1:0] rx_b;
   logic                       type_hit;
   logic [cpd_pkg::BYTE_W-1:0] len_payload;

   cpd_pkg::tab_cmd_type       tab_cmd;
   cpd_pkg::tab_status_type    tab_status;
   logic [SLOT_IDX_W-1:0]      tab_free_slot;
   logic [SLOT_IDX_W-1:0]      tab_reg_slot;
   logic [SLOT_IDX_W-1:0]      tab_match_slot;
   logic [SLOT_IDX_W+1:0]      reg_slot_wide;
   logic [SLOT_IDX_W+1:0]      match_slot_wide;
   logic [SLOT_IDX_W+1:0]      frame_slot_wide;

   assign req_word         = req_port.payload;
   assign req_port.ready   = !rsp_valid_ff || rsp_port.ready;
   assign req_accept       = req_port.valid && req_port.ready;
   assign rsp_port.valid   = rsp_valid_ff;
   assign rsp_port.payload = rsp_word_ff;
   assign rx_b             = req_word.rx_byte;

   assign type_hit = (rx_b == type_reply_ff) || (rx_b == type_write_ff) ||
                     (rx_b == type_eof_ff) || (rx_b == type_setopt_ff) ||
                     (rx_b == type_reset_ff);
   assign len_payload = (rx_b < cpd_pkg::LEN_OVERHEAD) ? '0 : rx_b - cpd_pkg::LEN_OVERHEAD;

   assign reg_slot_wide   = {2'b00, tab_reg_slot};
   assign match_slot_wide = {2'b00, tab_match_slot};
   assign frame_slot_wide = {2'b00, frame_slot_ff};

   cpd_slot_table #(
      .SLOT_COUNT (SLOT_COUNT),
      .SLOT_IDX_W (SLOT_IDX_W)
   ) u_slot_table (
      .clock      (clock),
      .reset      (reset),
      .cmd        (tab_cmd),
      .free_slot  (tab_free_slot),
      .match_byte (rx_b),
      .reg_slot   (tab_reg_slot),
      .match_slot (tab_match_slot),
      .status     (tab_status)
   );

   always_comb begin
      phase_in      = phase_ff;
      frame_type_in = frame_type_ff;
      bytes_left_in = bytes_left_ff;
      frame_chan_in = frame_chan_ff;
      frame_slot_in = frame_slot_ff;
      emit          = 1'b0;
      rsp_word_in   = '0;
      tab_cmd       = '0;
      tab_free_slot = frame_slot_ff;
      tab_cmd.reg_chan = req_word.channel;
      tab_cmd.reg_keep = req_word.keep_after_reply;

      if (req_accept) begin
         if (req_word.mode == cpd_pkg::MODE_REGISTER) begin
            tab_cmd.reg_en      = 1'b1;
            emit                = 1'b1;
            rsp_word_in.chan_id = req_word.channel;
            if (tab_status.reg_found) begin
               rsp_word_in.kind = cpd_pkg::KIND_REGISTERED;
               rsp_word_in.slot = reg_slot_wide[cpd_pkg::SLOT_OUT_W-1:0];
            end else begin
               rsp_word_in.kind = cpd_pkg::KIND_TABLE_FULL;
            end
         end else begin
            case (phase_ff)
               cpd_pkg::PH_LEN: begin
                  bytes_left_in = len_payload;
                  phase_in      = cpd_pkg::PH_CHAN;
               end
               cpd_pkg::PH_CHAN: begin
                  frame_chan_in = rx_b[cpd_pkg::CHAN_W-1:0];
                  if (tab_status.match_hit) begin
                     frame_slot_in = tab_match_slot;
                  end
                  if (tab_status.match_hit && bytes_left_ff <= rx_capacity_ff) begin
                     emit                  = 1'b1;
                     rsp_word_in.kind      = cpd_pkg::KIND_HEADER;
                     rsp_word_in.chan_id   = rx_b[cpd_pkg::CHAN_W-1:0];
                     rsp_word_in.slot      = match_slot_wide[cpd_pkg::SLOT_OUT_W-1:0];
                     rsp_word_in.type_code = frame_type_ff;
                     rsp_word_in.length    = bytes_left_ff;
                     rsp_word_in.done_res  = (bytes_left_ff == '0);
                     if (bytes_left_ff == '0) begin
                        tab_cmd.free_en = 1'b1;
                        tab_free_slot   = tab_match_slot;
                        phase_in        = cpd_pkg::PH_IDLE;
                     end else begin
                        phase_in = cpd_pkg::PH_DATA;
                     end
                  end else begin
                     phase_in = (bytes_left_ff == '0) ? cpd_pkg::PH_IDLE : cpd_pkg::PH_SKIP;
                  end
               end
               cpd_pkg::PH_DATA: begin
                  if (bytes_left_ff != '0) begin
                     bytes_left_in = bytes_left_ff - 8'd1;
                  end
                  emit                  = 1'b1;
                  rsp_word_in.kind      = cpd_pkg::KIND_DATA;
                  rsp_word_in.chan_id   = frame_chan_ff;
                  rsp_word_in.slot      = frame_slot_wide[cpd_pkg::SLOT_OUT_W-1:0];
                  rsp_word_in.type_code = frame_type_ff;
                  rsp_word_in.data_byte = rx_b;
                  rsp_word_in.done_res  = (bytes_left_ff <= 8'd1);
                  if (bytes_left_ff <= 8'd1) begin
                     tab_cmd.free_en = 1'b1;
                     phase_in        = cpd_pkg::PH_IDLE;
                  end
               end
               cpd_pkg::PH_SKIP: begin
                  if (bytes_left_ff != '0) begin
                     bytes_left_in = bytes_left_ff - 8'd1;
                  end
                  if (bytes_left_ff <= 8'd1) begin
                     phase_in = cpd_pkg::PH_IDLE;
                  end
               end
               default: begin
                  phase_in = cpd_pkg::PH_IDLE;
                  if (rx_b == sync_code_ff) begin
                     emit                  = 1'b1;
                     rsp_word_in.kind      = cpd_pkg::KIND_SYNC;
                     rsp_word_in.data_byte = sync_code_ff;
                  end else if (type_hit) begin
                     frame_type_in = rx_b;
                     phase_in      = cpd_pkg::PH_LEN;
                  end
               end
            endcase
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= cpd_pkg::PH_IDLE;
         frame_type_ff <= '0;
         bytes_left_ff <= '0;
         frame_chan_ff <= '0;
         frame_slot_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         frame_type_ff <= frame_type_in;
         bytes_left_ff <= bytes_left_in;
         frame_chan_ff <= frame_chan_in;
         frame_slot_ff <= frame_slot_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (emit) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_code_ff   <= '0;
         type_reply_ff  <= '0;
         type_write_ff  <= '0;
         type_eof_ff    <= '0;
         type_setopt_ff <= '0;
         type_reset_ff  <= '0;
         rx_capacity_ff <= cpd_pkg::CAPACITY_RESET;
      end else if (csr_we) begin
         case (csr_index)
            cpd_pkg::CSR_SYNC_CODE:   sync_code_ff   <= csr_wdata;
            cpd_pkg::CSR_TYPE_REPLY:  type_reply_ff  <= csr_wdata;
            cpd_pkg::CSR_TYPE_WRITE:  type_write_ff  <= csr_wdata;
            cpd_pkg::CSR_TYPE_EOF:    type_eof_ff    <= csr_wdata;
            cpd_pkg::CSR_TYPE_SETOPT: type_setopt_ff <= csr_wdata;
            cpd_pkg::CSR_TYPE_RESET:  type_reset_ff  <= csr_wdata;
            cpd_pkg::CSR_RX_CAPACITY: rx_capacity_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   a_data_has_bytes: assert property (@(posedge clock) disable iff (reset)
      phase_ff == cpd_pkg::PH_DATA || phase_ff == cpd_pkg::PH_SKIP |->
         bytes_left_ff != '0)
      else $error("payload phase with no bytes left");

   a_header_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.kind == cpd_pkg::KIND_HEADER |->
         rsp_word_ff.done_res == (rsp_word_ff.length == '0))
      else $error("header done mark disagrees with length");

   a_register_answers: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_word.mode == cpd_pkg::MODE_REGISTER |=>
         rsp_valid_ff && (rsp_word_ff.kind == cpd_pkg::KIND_REGISTERED ||
                          rsp_word_ff.kind == cpd_pkg::KIND_TABLE_FULL))
      else $error("registration gave no answer");

   a_register_keeps_phase: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_word.mode == cpd_pkg::MODE_REGISTER |=>
         phase_ff == $past(phase_ff))
      else $error("registration disturbed frame parsing");

endmodule
